// ===== src/bsr_pkg.sv =====
// Shared types and constants of the byte stream reassembler.
package bsr_pkg;

  localparam int CAPACITY_DEF = 64;   // default ring size in bytes
  localparam int IDX_W        = 32;   // stream index width
  localparam int BYTE_W       = 8;
  localparam int PEND_W       = 7;    // width of the pending count field
  localparam int QDEPTH       = 2;    // depth of the word queue between front and back
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);
  localparam int S_TDATA_W    = 40;
  localparam int M_TDATA_W    = 16;

  // One input word as the back end sees it, with the end index worked out.
  typedef struct packed {
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic              carries_byte;
    logic              eof_flag;
    logic [IDX_W-1:0]  eof_end;
  } bsr_item_t;

  // One result word.
  typedef struct packed {
    logic              out_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_ended;
    logic [PEND_W-1:0] pending_count;
  } bsr_result_t;

  typedef enum logic [2:0] {
    BSR_IDLE,
    BSR_APPLY,
    BSR_SCAN,
    BSR_EMIT_RD,
    BSR_EMIT_WR,
    BSR_STATUS
  } bsr_state_t;

endpackage

// ===== src/bsr_front.sv =====
// Front end: accepts input words, unpacks them and queues them for the back end.
module bsr_front import bsr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,
  input  logic                 s_axis_tlast,
  output logic                 item_valid,
  input  logic                 item_pop,
  output bsr_item_t            item
);

  bsr_item_t          queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               push;
  logic               pop;
  bsr_item_t          in_item;

  assign s_axis_tready = (fill != QCNT_W'(QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = (fill != '0);
  assign pop           = item_pop && item_valid;
  assign item          = queue[rd_ptr];

  always_comb begin
    in_item.byte_index   = s_axis_tdata[IDX_W-1:0];
    in_item.byte_value   = s_axis_tdata[IDX_W+BYTE_W-1:IDX_W];
    in_item.carries_byte = s_axis_tuser[0];
    in_item.eof_flag     = s_axis_tlast;
    // end index is one past a carried byte, or the marker index itself
    in_item.eof_end      = s_axis_tdata[IDX_W-1:0] + IDX_W'(s_axis_tuser[0]);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/bsr_back.sv =====
// Back end: stores bytes in the ring, scans the contiguous run and emits it.
module bsr_back import bsr_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_pop,
  input  bsr_item_t   item,
  input  logic        out_free,
  output logic        res_push,
  output bsr_result_t res
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  bsr_state_t         state;
  bsr_state_t         state_next;

  bsr_item_t          cur;
  logic [IDX_W-1:0]   next_index;
  logic               eof_known;
  logic [IDX_W-1:0]   eof_position;
  logic [CW-1:0]      held;
  logic               ended;
  logic [SW-1:0]      head;
  logic [CAPACITY-1:0] slot_valid;
  logic [BYTE_W-1:0]  slot_byte [CAPACITY];

  logic [IDX_W-1:0]   scan_idx;
  logic [SW-1:0]      scan_slot;
  logic [CW-1:0]      cnt;
  logic [SW-1:0]      rd_slot;
  logic [CW-1:0]      left;
  logic [BYTE_W-1:0]  rd_data;

  logic               eof_known_n;
  logic [IDX_W-1:0]   eof_pos_n;
  logic [IDX_W-1:0]   win_off;
  logic [IDX_W-1:0]   lim;
  logic               take;
  logic [SW:0]        ins_sum;
  logic [SW-1:0]      ins_slot;
  logic               store;
  logic               scan_stop;
  logic [IDX_W-1:0]   scan_gap;
  logic               do_apply;
  logic               do_scan;
  logic               do_read;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(CAPACITY - 1)) ? '0 : s + 1'b1;
  endfunction

  // Classify the current word against the window and the end index.
  always_comb begin
    eof_known_n = eof_known | cur.eof_flag;
    eof_pos_n   = cur.eof_flag ? cur.eof_end : eof_position;
    win_off     = cur.byte_index - next_index;
    lim         = eof_pos_n - next_index;
    take        = cur.carries_byte && (win_off < IDX_W'(CAPACITY))
                  && !(eof_known_n && (win_off >= lim));
    ins_sum     = {1'b0, head} + {1'b0, win_off[SW-1:0]};
    ins_slot    = (ins_sum >= (SW+1)'(CAPACITY)) ? SW'(ins_sum - (SW+1)'(CAPACITY))
                                                 : ins_sum[SW-1:0];
    store       = take && !slot_valid[ins_slot];
    scan_stop   = (eof_known && (scan_idx == eof_position)) || !slot_valid[scan_slot]
                  || (cnt == CW'(CAPACITY));
    scan_gap    = scan_idx - eof_position;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BSR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    res_push   = 1'b0;
    do_apply   = 1'b0;
    do_scan    = 1'b0;
    do_read    = 1'b0;
    case (state)
      BSR_IDLE: begin
        if (item_valid) begin
          item_pop   = 1'b1;
          state_next = BSR_APPLY;
        end
      end
      BSR_APPLY: begin
        do_apply   = !ended;
        state_next = ended ? BSR_STATUS : BSR_SCAN;
      end
      BSR_SCAN: begin
        do_scan = 1'b1;
        if (scan_stop) begin
          state_next = (cnt == '0) ? BSR_STATUS : BSR_EMIT_RD;
        end
      end
      BSR_EMIT_RD: begin
        do_read    = 1'b1;
        state_next = BSR_EMIT_WR;
      end
      BSR_EMIT_WR: begin
        if (out_free) begin
          res_push   = 1'b1;
          state_next = (left == '0) ? BSR_IDLE : BSR_EMIT_RD;
        end
      end
      BSR_STATUS: begin
        if (out_free) begin
          res_push   = 1'b1;
          state_next = BSR_IDLE;
        end
      end
      default: state_next = BSR_IDLE;
    endcase
  end

  always_comb begin
    res.out_valid     = (state == BSR_EMIT_WR);
    res.out_byte      = (state == BSR_EMIT_WR) ? rd_data : '0;
    res.run_last      = (state == BSR_STATUS) || (left == '0);
    res.stream_ended  = ended;
    res.pending_count = PEND_W'(held);
  end

  // Stream state and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_index   <= '0;
      eof_known    <= 1'b0;
      eof_position <= '0;
      held         <= '0;
      ended        <= 1'b0;
      head         <= '0;
      slot_valid   <= '0;
    end else begin
      if (do_apply) begin
        eof_known    <= eof_known_n;
        eof_position <= eof_pos_n;
        if (store) begin
          slot_valid[ins_slot] <= 1'b1;
          held                 <= held + 1'b1;
        end
      end
      if (do_scan && scan_stop) begin
        next_index <= scan_idx;
        head       <= scan_slot;
        held       <= held - cnt;
        ended      <= eof_known && !scan_gap[IDX_W-1];
      end
      if (do_read) begin
        slot_valid[rd_slot] <= 1'b0;
      end
    end
  end

  // Work registers of the current word.
  always_ff @(posedge clk) begin
    if (item_pop) begin
      cur <= item;
    end
    if (do_apply) begin
      scan_idx  <= next_index;
      scan_slot <= head;
      cnt       <= '0;
    end
    if (do_scan) begin
      if (!scan_stop) begin
        scan_idx  <= scan_idx + 1'b1;
        scan_slot <= slot_inc(scan_slot);
        cnt       <= cnt + 1'b1;
      end else begin
        rd_slot <= head;
        left    <= cnt;
      end
    end
    if (do_read) begin
      rd_slot <= slot_inc(rd_slot);
      left    <= left - 1'b1;
    end
  end

  // Byte store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_apply && store) begin
      slot_byte[ins_slot] <= cur.byte_value;
    end
    if (do_read) begin
      rd_data <= slot_byte[rd_slot];
    end
  end

endmodule

// ===== src/byte_stream_reassembler.sv =====
// Top level of the byte stream reassembler: front queue, back engine, output register.
// The back engine handles one word at a time: it pops the word, applies it to the ring, then
// scans the contiguous run one slot per cycle; it then reads and emits each released byte in
// turn, or sends one status word when no byte is released, each waiting for a free output
// register. After the end it goes from apply straight to the status word. The ring has a
// single read port. The front queue keeps taking words while the back engine is busy, if it has room.
// Reset (rst, synchronous) clears the queue, stream state and all slot valid bits.
module byte_stream_reassembler import bsr_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [31:0] byte_index, [39:32] byte_value
  input  logic [0:0]           s_axis_tuser,  // [0] carries_byte
  input  logic                 s_axis_tlast,  // eof_flag
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [7:0] out_byte, [14:8] pending_count, [15] 0
  output logic [1:0]           m_axis_tuser,  // [0] out_valid, [1] stream_ended
  output logic                 m_axis_tlast   // run_last
);

  logic        item_valid;
  logic        item_pop;
  bsr_item_t   item;
  logic        out_free;
  logic        res_push;
  bsr_result_t res;
  bsr_result_t out_reg;

  // Front: take words whenever the queue has room.
  bsr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .item_valid    (item_valid),
    .item_pop      (item_pop),
    .item          (item)
  );

  // Back: store, scan and drain one queued word at a time.
  bsr_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item),
    .out_free   (out_free),
    .res_push   (res_push),
    .res        (res)
  );

  // Output register: load when empty or being drained this cycle.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_reg <= res;
    end
  end

  // Pack the result word onto the master side.
  assign m_axis_tdata = {1'b0, out_reg.pending_count, out_reg.out_byte};
  assign m_axis_tuser = {out_reg.stream_ended, out_reg.out_valid};
  assign m_axis_tlast = out_reg.run_last;

endmodule
